// ----- rtl/y2rbob_pkg.sv -----
// Package: fixed-point coefficients and offsets for the YUV to RGB field router.
`timescale 1ns / 1ps
`default_nettype none

package y2rbob_pkg;

  // Input and coordinate widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned SAMP_W  = 8;

  // Offset samples (C, D, E) are 9-bit signed
  localparam int unsigned OFS_W = SAMP_W + 1;

  // Channel sums fit in 27 bits signed with margin
  localparam int unsigned SUM_W = 27;

  // Q16 fraction bits
  localparam int unsigned FRAC_W = 16;

  // BT.601 coefficients in Q16
  localparam logic [16:0] Q16_R_V = 17'd91881;
  localparam logic [16:0] Q16_G_U = 17'd22544;
  localparam logic [16:0] Q16_G_V = 17'd46793;
  localparam logic [16:0] Q16_B_U = 17'd116130;

  // Sample offsets
  localparam logic [SAMP_W-1:0] LUMA_OFFSET   = 8'd16;
  localparam logic [SAMP_W-1:0] CHROMA_OFFSET = 8'd128;

  // Channel ceiling
  localparam logic [SAMP_W-1:0] CHAN_MAX = 8'd255;

  // Pipeline depth from input beat to output register
  localparam int unsigned PIPE_DEPTH = 4;

  // Floor the Q16 sum and clamp it to 0..255
  function automatic logic [SAMP_W-1:0] sat_q16(input logic signed [SUM_W-1:0] v);
    logic [SAMP_W-1:0] q;
    begin
      q = v[FRAC_W+SAMP_W-1:FRAC_W];
      if (v[SUM_W-1]) begin
        sat_q16 = '0;
      end else if (|v[SUM_W-2:FRAC_W+SAMP_W]) begin
        sat_q16 = CHAN_MAX;
      end else begin
        sat_q16 = q;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/yuv420_to_rgb_bob_field_router.sv -----
// Top level: pipelined BT.601 YUV to RGB converter with bob field routing.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in      | input     | in_valid/in_stall  | col, row, luma, chroma_blue, chroma_red
//   out     | output    | out_valid/out_stall| to_field_b, col, row_first, red, green, blue
//   cfg     | input     | cfg_wr_en          | cfg_wr_data = top_field_first
//
// One beat per cycle sustained while out_stall is low; each beat passes through offset, multiply, sum, clamp.
// Each stage holds its beat while the one after it is full and not draining, so
// bubbles collapse and in_stall only rises when all four stages are occupied.
// Synchronous active-low reset empties the pipeline and sets top_field_first to 1.
// top_field_first is sampled when a beat enters the first stage.
`timescale 1ns / 1ps
`default_nettype none

module yuv420_to_rgb_bob_field_router
  import y2rbob_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,

  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [COORD_W-1:0] in_col,
  input  wire logic [COORD_W-1:0] in_row,
  input  wire logic [SAMP_W-1:0]  in_luma,
  input  wire logic [SAMP_W-1:0]  in_chroma_blue,
  input  wire logic [SAMP_W-1:0]  in_chroma_red,

  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               out_to_field_b,
  output      logic [COORD_W-1:0] out_col,
  output      logic [COORD_W-1:0] out_row_first,
  output      logic [SAMP_W-1:0]  out_red,
  output      logic [SAMP_W-1:0]  out_green,
  output      logic [SAMP_W-1:0]  out_blue
);

  // Configuration register
  logic tff_r;

  // Stage valids
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  // Routing info carried along
  logic               s1_fb_r, s2_fb_r, s3_fb_r, s4_fb_r;
  logic [COORD_W-1:0] s1_col_r, s2_col_r, s3_col_r, s4_col_r;
  logic [COORD_W-1:0] s1_row_r, s2_row_r, s3_row_r, s4_row_r;

  // Stage 1: offset samples
  logic signed [OFS_W-1:0] s1_c_r, s1_d_r, s1_e_r;

  // Stage 2: products
  logic signed [SUM_W-1:0] s2_cs_r, s2_rv_r, s2_gu_r, s2_gv_r, s2_bu_r;

  // Stage 3: channel sums
  logic signed [SUM_W-1:0] s3_rs_r, s3_gs_r, s3_bs_r;

  // Stage 4: clamped channels
  logic [SAMP_W-1:0] s4_red_r, s4_green_r, s4_blue_r;

  // Config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tff_r <= 1'b1;
    end else if (cfg_wr_en) begin
      tff_r <= cfg_wr_data;
    end
  end

  // Ready chain: a stage takes a beat when empty or when it drains
  assign s4_rdy   = !s4_v_r || !out_stall;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  always_comb begin
    s1_v_nxt = s1_rdy ? in_valid : s1_v_r;
    s2_v_nxt = s2_rdy ? s1_v_r   : s2_v_r;
    s3_v_nxt = s3_rdy ? s2_v_r   : s3_v_r;
    s4_v_nxt = s4_rdy ? s3_v_r   : s4_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      s4_v_r <= s4_v_nxt;
    end
  end

  // Stage 1: subtract offsets, pick field, round row down to even
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_c_r   <= $signed({1'b0, in_luma})        - $signed({1'b0, LUMA_OFFSET});
      s1_d_r   <= $signed({1'b0, in_chroma_blue}) - $signed({1'b0, CHROMA_OFFSET});
      s1_e_r   <= $signed({1'b0, in_chroma_red})  - $signed({1'b0, CHROMA_OFFSET});
      s1_fb_r  <= (in_row[0] == tff_r);
      s1_col_r <= in_col;
      s1_row_r <= {in_row[COORD_W-1:1], 1'b0};
    end
  end

  // Stage 2: one constant multiply per chroma term, luma scaled by a shift
  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_cs_r  <= SUM_W'(s1_c_r) <<< FRAC_W;
      s2_rv_r  <= SUM_W'(s1_e_r) * SUM_W'($signed({1'b0, Q16_R_V}));
      s2_gu_r  <= SUM_W'(s1_d_r) * SUM_W'($signed({1'b0, Q16_G_U}));
      s2_gv_r  <= SUM_W'(s1_e_r) * SUM_W'($signed({1'b0, Q16_G_V}));
      s2_bu_r  <= SUM_W'(s1_d_r) * SUM_W'($signed({1'b0, Q16_B_U}));
      s2_fb_r  <= s1_fb_r;
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
    end
  end

  // Stage 3: channel sums
  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_rs_r  <= s2_cs_r + s2_rv_r;
      s3_gs_r  <= s2_cs_r - s2_gu_r - s2_gv_r;
      s3_bs_r  <= s2_cs_r + s2_bu_r;
      s3_fb_r  <= s2_fb_r;
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
    end
  end

  // Stage 4: floor and clamp into the output register
  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v_r) begin
      s4_red_r   <= sat_q16(s3_rs_r);
      s4_green_r <= sat_q16(s3_gs_r);
      s4_blue_r  <= sat_q16(s3_bs_r);
      s4_fb_r    <= s3_fb_r;
      s4_col_r   <= s3_col_r;
      s4_row_r   <= s3_row_r;
    end
  end

  // Outputs
  assign out_valid      = s4_v_r;
  assign out_to_field_b = s4_fb_r;
  assign out_col        = s4_col_r;
  assign out_row_first  = s4_row_r;
  assign out_red        = s4_red_r;
  assign out_green      = s4_green_r;
  assign out_blue       = s4_blue_r;

endmodule

`default_nettype wire

// ----- rtl/y2rbob_checker.sv -----
// Checker: port-level assertions for the YUV to RGB field router, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module y2rbob_checker
  import y2rbob_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_to_field_b,
  input wire logic [COORD_W-1:0] out_col,
  input wire logic [COORD_W-1:0] out_row_first,
  input wire logic [SAMP_W-1:0]  out_red,
  input wire logic [SAMP_W-1:0]  out_green,
  input wire logic [SAMP_W-1:0]  out_blue
);

  // A stalled result beat stays up and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_to_field_b) && $stable(out_col)
      && $stable(out_row_first) && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result beat changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  // An accepted beat reaches the output through every stage when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not reach the output in time");

  // Bob rows always start on an even line
  a_row_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_row_first[0])
    else $error("first output row is odd");

endmodule

bind yuv420_to_rgb_bob_field_router y2rbob_checker u_y2rbob_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_to_field_b (out_to_field_b),
  .out_col        (out_col),
  .out_row_first  (out_row_first),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue)
);

`default_nettype wire
